// ===== sv/qze_pkg.sv =====
// Shared constants for the quaternion to ZYX Euler angle pipeline.
// Holds fixed-point widths, stage counts and the CORDIC arctangent table.
// No dependencies.
package qze_pkg;

  // products of two quaternion components carry 28 fraction bits
  localparam int NORM_FRAC = 28;
  localparam int NW        = 34;   // normalized product width
  localparam int TW        = 36;   // term width (t1..t5)
  localparam int CLW       = 30;   // clamped asin argument width
  localparam int RADW      = 58;   // square root radicand width (even)
  localparam int SQ_STEPS  = RADW / 2;
  localparam int RW        = 29;   // root width
  localparam int REM_W     = 32;   // square root remainder width
  localparam int CW        = 38;   // CORDIC x/y width
  localparam int ZW        = 34;   // CORDIC angle width, 2^32 = full turn

  localparam int TERMS_LAT = 5;
  localparam int OUT_LAT   = 3;

  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;

  // atan(2^-i) in binary angle units
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ===== sv/quaternion_to_zyx_euler.sv =====
// Quaternion to ZYX Euler angle converter, top level.
// Slave channel takes a pose item, master channel returns position and
// yaw, pitch, roll. Each item goes through a fixed pipeline: product and
// term stages, a one-bit-per-stage square root for the pitch cosine,
// three parallel CORDIC lanes, then scaling to radians.
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances together.
// When the receiver holds m_tready low with a result waiting, the pipeline
// freezes and s_tready drops; nothing is lost or repeated.
// A synchronous reset clears all valid bits; data registers are not reset.
// The block keeps no state between items.
// Depends on qze_pkg, qze_terms, qze_sqrt, qze_cordic, qze_angle.
module quaternion_to_zyx_euler import qze_pkg::*; #(
  parameter int QUAT_WIDTH   = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int IN_W  = ((96 + 4 * QUAT_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((96 + 3 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // out_x, out_y, out_z, yaw_angle, pitch_angle, roll_angle
  output logic [OUT_W-1:0] m_tdata
);

  localparam int QW  = QUAT_WIDTH;
  localparam int LAT = TERMS_LAT + SQ_STEPS + CORDIC_STEPS + 1 + OUT_LAT;
  localparam int SIDE_W = 4 * TW + CLW;

  logic                  en;
  logic [LAT-1:0]        vld;
  logic [95:0]           pos [LAT];
  logic signed [TW-1:0]  t1, t2, t4, t5, u1, u2, u4, u5;
  logic signed [CLW-1:0] t3c, u3;
  logic [RADW-1:0]       c2;
  logic [RW-1:0]         root;
  logic [SIDE_W-1:0]     side_out;
  logic signed [ZW-1:0]  z_yaw, z_pitch, z_roll;
  logic [ANGLE_WIDTH-1:0] yaw, pitch, roll;

  // global advance: move when the output slot is empty or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // position rides along with the item
  always_ff @(posedge clk) begin
    if (en) begin
      pos[0] <= s_tdata[95:0];
      for (int k = 1; k < LAT; k++) pos[k] <= pos[k-1];
    end
  end

  qze_terms #(.QW(QW)) u_terms (
    .clk (clk),
    .en  (en),
    .qx  (s_tdata[96 +: QW]),
    .qy  (s_tdata[96 + QW +: QW]),
    .qz  (s_tdata[96 + 2 * QW +: QW]),
    .qw  (s_tdata[96 + 3 * QW +: QW]),
    .t1  (t1),
    .t2  (t2),
    .t3c (t3c),
    .t4  (t4),
    .t5  (t5),
    .c2  (c2)
  );

  qze_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (c2),
    .side_in  ({t1, t2, t3c, t4, t5}),
    .root_out (root),
    .side_out (side_out)
  );

  assign {u1, u2, u3, u4, u5} = side_out;

  qze_cordic #(.STEPS(CORDIC_STEPS)) u_cor_yaw (
    .clk (clk), .en (en), .y_in (u1), .x_in (u2), .ang (z_yaw)
  );

  qze_cordic #(.STEPS(CORDIC_STEPS)) u_cor_pitch (
    .clk (clk), .en (en), .y_in (TW'(u3)), .x_in (TW'({1'b0, root})), .ang (z_pitch)
  );

  qze_cordic #(.STEPS(CORDIC_STEPS)) u_cor_roll (
    .clk (clk), .en (en), .y_in (u4), .x_in (u5), .ang (z_roll)
  );

  qze_angle #(.AW(ANGLE_WIDTH)) u_ang_yaw (
    .clk (clk), .en (en), .z (z_yaw), .angle (yaw)
  );

  qze_angle #(.AW(ANGLE_WIDTH)) u_ang_pitch (
    .clk (clk), .en (en), .z (z_pitch), .angle (pitch)
  );

  qze_angle #(.AW(ANGLE_WIDTH)) u_ang_roll (
    .clk (clk), .en (en), .z (z_roll), .angle (roll)
  );

  assign m_tdata = OUT_W'({roll, pitch, yaw, pos[LAT-1]});

`ifndef NO_ASSERTIONS
  // an empty output slot must let the pipeline take an item
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("pipeline blocked with empty output");

  // a stalled result freezes every stage's valid bit
  a_freeze_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(vld)) else $error("pipeline moved during stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0)) else $error("valid bits survive reset");
`endif

endmodule

// ===== sv/qze_terms.sv =====
// Quaternion products, rotation-matrix terms, asin clamp and 1 - s^2.
// Five register stages. Depends on qze_pkg.
module qze_terms import qze_pkg::*; #(
  parameter int QW = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [QW-1:0]  qx,
  input  logic signed [QW-1:0]  qy,
  input  logic signed [QW-1:0]  qz,
  input  logic signed [QW-1:0]  qw,
  output logic signed [TW-1:0]  t1,
  output logic signed [TW-1:0]  t2,
  output logic signed [CLW-1:0] t3c,
  output logic signed [TW-1:0]  t4,
  output logic signed [TW-1:0]  t5,
  output logic [RADW-1:0]       c2
);

  localparam int SH = 2 * (QW - 2) - NORM_FRAC;
  localparam int NP = 10;

  logic signed [2*QW-1:0] pr   [NP];
  logic signed [NW-1:0]   nrm  [NP];
  logic signed [NW-1:0]   prod [NP];
  logic signed [TW-1:0]   s1, s2, s3, s4, s5;
  logic signed [TW-1:0]   c1, c_2, c4, c5;
  logic signed [TW-1:0]   d1, d2, d4, d5;
  logic signed [CLW-1:0]  t3cl, t3r, e3;
  logic signed [2*CLW-1:0] sq;

  // xx yy zz ww xy wz xz wy yz wx
  assign pr[0] = qx * qx;
  assign pr[1] = qy * qy;
  assign pr[2] = qz * qz;
  assign pr[3] = qw * qw;
  assign pr[4] = qx * qy;
  assign pr[5] = qw * qz;
  assign pr[6] = qx * qz;
  assign pr[7] = qw * qy;
  assign pr[8] = qy * qz;
  assign pr[9] = qw * qx;

  // bring every product to 28 fraction bits
  for (genvar k = 0; k < NP; k++) begin : g_norm
    if (SH >= 0) begin : g_r
      assign nrm[k] = NW'(pr[k] >>> SH);
    end else begin : g_l
      assign nrm[k] = NW'(pr[k]) <<< (-SH);
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NP; k++) prod[k] <= nrm[k];
    end
  end

  // stage 2: matrix terms
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= (TW'(prod[4]) + TW'(prod[5])) <<< 1;
      s2 <= TW'(prod[3]) + TW'(prod[0]) - TW'(prod[1]) - TW'(prod[2]);
      s3 <= (TW'(prod[7]) - TW'(prod[6])) <<< 1;
      s4 <= (TW'(prod[8]) + TW'(prod[9])) <<< 1;
      s5 <= TW'(prod[3]) - TW'(prod[0]) - TW'(prod[1]) + TW'(prod[2]);
    end
  end

  // stage 3: clamp asin argument to [-1, 1]
  always_comb begin
    priority if (s3 > (TW'(1) <<< NORM_FRAC)) begin
      t3cl = CLW'(1) <<< NORM_FRAC;
    end else if (s3 < -(TW'(1) <<< NORM_FRAC)) begin
      t3cl = -(CLW'(1) <<< NORM_FRAC);
    end else begin
      t3cl = CLW'(s3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= s1;
      c_2 <= s2;
      c4  <= s4;
      c5  <= s5;
      t3r <= t3cl;
    end
  end

  // stage 4: square; stage 5: 1 - s^2, clamped argument kept in step
  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= t3r * t3r;
      e3  <= t3r;
      d1  <= c1;
      d2  <= c_2;
      d4  <= c4;
      d5  <= c5;
      c2  <= (RADW'(1) << (2 * NORM_FRAC)) - RADW'(sq);
      t3c <= e3;
      t1  <= d1;
      t2  <= d2;
      t4  <= d4;
      t5  <= d5;
    end
  end

endmodule

// ===== sv/qze_sqrt.sv =====
// Pipelined floor integer square root, one result bit per stage.
// Carries side data alongside. Depends on qze_pkg.
module qze_sqrt import qze_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RADW-1:0]   rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [RW-1:0]     root_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [REM_W-1:0]  rem  [SQ_STEPS+1];
  logic [RW-1:0]     root [SQ_STEPS+1];
  logic [RADW-1:0]   rad  [SQ_STEPS+1];
  logic [SIDE_W-1:0] side [SQ_STEPS+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_in;
  assign side[0] = side_in;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    logic [REM_W-1:0] rem_sh, trial;
    assign rem_sh = {rem[k][REM_W-3:0], rad[k][RADW-1 -: 2]};
    assign trial  = REM_W'({root[k], 2'b01});

    // restoring step: try to set the next root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem[k+1]  <= rem_sh - trial;
          root[k+1] <= {root[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= rem_sh;
          root[k+1] <= {root[k][RW-2:0], 1'b0};
        end
        rad[k+1]  <= rad[k] << 2;
        side[k+1] <= side[k];
      end
    end
  end

  assign root_out = root[SQ_STEPS];
  assign side_out = side[SQ_STEPS];

endmodule

// ===== sv/qze_cordic.sv =====
// One CORDIC vectoring lane computing atan2(y, x) in binary angle units.
// Quadrant setup stage plus one stage per iteration. Depends on qze_pkg.
module qze_cordic import qze_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [TW-1:0] y_in,
  input  logic signed [TW-1:0] x_in,
  output logic signed [ZW-1:0] ang
);

  logic signed [CW-1:0] x   [STEPS+1];
  logic signed [CW-1:0] y   [STEPS+1];
  logic signed [ZW-1:0] z   [STEPS+1];
  logic                 fix [STEPS+1];

  // setup: zero y gives a fixed angle, left half plane rotates by 90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in == '0) begin
        fix[0] <= 1'b1;
        x[0]   <= CW'(x_in);
        y[0]   <= '0;
        z[0]   <= (x_in < 0) ? (ZW'(1) <<< 31) : '0;
      end else if (x_in < 0) begin
        fix[0] <= 1'b0;
        if (y_in >= 0) begin
          x[0] <= CW'(y_in);
          y[0] <= -CW'(x_in);
          z[0] <= ZW'(1) <<< 30;
        end else begin
          x[0] <= -CW'(y_in);
          y[0] <= CW'(x_in);
          z[0] <= -(ZW'(1) <<< 30);
        end
      end else begin
        fix[0] <= 1'b0;
        x[0]   <= CW'(x_in);
        y[0]   <= CW'(y_in);
        z[0]   <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    localparam logic signed [ZW-1:0] A = ZW'(ATAN_TAB[i % 32]);
    logic signed [CW-1:0] xs, ys;
    assign xs = x[i] >>> (i % 32);
    assign ys = y[i] >>> (i % 32);

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        fix[i+1] <= fix[i];
        if (fix[i]) begin
          x[i+1] <= x[i];
          y[i+1] <= y[i];
          z[i+1] <= z[i];
        end else if (y[i] >= 0) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + A;
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - A;
        end
      end
    end
  end

  assign ang = z[STEPS];

endmodule

// ===== sv/qze_angle.sv =====
// Scales a binary angle to radians (times pi), rounds and saturates.
// Three register stages. Depends on qze_pkg.
module qze_angle import qze_pkg::*; #(
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] z,
  output logic [AW-1:0]        angle
);

  localparam int SH = 61 - (AW - 3);
  localparam logic [64:0] MAXV = (65'(1) << (AW - 1)) - 65'(1);

  logic        neg1, neg2;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [64:0] r;

  assign r = (65'(prod) + (65'(1) << (SH - 1))) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: sign and magnitude
      neg1 <= z < 0;
      mag  <= (z < 0) ? 32'(-z) : 32'(z);
      // stage 2: times pi
      neg2 <= neg1;
      prod <= 64'(mag) * 64'(PI_Q30);
      // stage 3: round half away from zero and saturate
      if (neg2) begin
        angle <= (r > MAXV + 65'(1)) ? AW'(65'(0) - MAXV - 65'(1)) : AW'(65'(0) - r);
      end else begin
        angle <= (r > MAXV) ? AW'(MAXV) : AW'(r);
      end
    end
  end

endmodule

// ===== tb/quaternion_to_zyx_euler_tb.sv =====
// Testbench for quaternion_to_zyx_euler: pose items in, position and ZYX angles out.
// It predicts each result from its own fixed-point CORDIC model and checks it field by field.
// Depends on qze_pkg and the quaternion_to_zyx_euler RTL.
module quaternion_to_zyx_euler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qze_pkg::*;

  localparam int QW = 16;
  localparam int AW = 16;
  localparam int STEPS = 16;
  localparam int IN_W = 160;
  localparam int OUT_W = 144;
  localparam int LATENCY = 5 + 29 + STEPS + 1 + 3;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1030;
  localparam longint ONE_Q28 = 64'sd1 << 28;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } euler_t;

  // directed row: pose, and whether the angles are typed in
  typedef struct {
    pose_t pose;
    bit    fixed;
    euler_t angles;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  euler_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int idle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit sending_done = 1'b0;

  always #1 clk = ~clk;

  quaternion_to_zyx_euler u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // product of two Q2.14 components, rescaled to 28 fraction bits (exact here)
  function automatic longint qmul(longint a, longint b);
    return (a * b) <<< (28 - 2 * (QW - 2));
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC, result in binary angle units
  function automatic longint bam_atan2(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (y == 0) return (x < 0) ? 64'sh80000000 : 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sh40000000;
      end else begin
        x = -y; y = t; z = -64'sh40000000;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  // scale by pi, round magnitude to nearest, saturate to AW bits
  function automatic logic signed [15:0] bam_to_rad(longint ang);
    longint unsigned mag, r;
    int sh;
    longint maxv;
    sh = 61 - (AW - 3);
    mag = (ang < 0) ? longint'(-ang) : ang;
    r = (mag * longint'(PI_Q30) + (64'd1 << (sh - 1))) >> sh;
    maxv = (64'sd1 <<< (AW - 1)) - 1;
    if (ang < 0) return (r > maxv + 1) ? 16'sh8000 : 16'(-longint'(r));
    return (r > maxv) ? 16'sh7fff : 16'(r);
  endfunction

  function automatic euler_t pose_to_euler(pose_t p);
    longint qx, qy, qz, qw, xx, yy, zz, ww, t1, t2, t3, t4, t5;
    longint unsigned c2;
    euler_t e;
    qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
    xx = qmul(qx, qx); yy = qmul(qy, qy); zz = qmul(qz, qz); ww = qmul(qw, qw);
    t1 = 2 * (qmul(qx, qy) + qmul(qw, qz));
    t2 = ww + xx - yy - zz;
    t3 = -2 * (qmul(qx, qz) - qmul(qw, qy));
    t4 = 2 * (qmul(qy, qz) + qmul(qw, qx));
    t5 = ww - xx - yy + zz;
    if (t3 > ONE_Q28) t3 = ONE_Q28;
    if (t3 < -ONE_Q28) t3 = -ONE_Q28;
    c2 = (64'd1 << 56) - longint'(t3 * t3);
    e.x = p.px; e.y = p.py; e.z = p.pz;
    e.yaw = bam_to_rad(bam_atan2(t1, t2));
    e.pitch = bam_to_rad(bam_atan2(t3, int_sqrt(c2)));
    e.roll = bam_to_rad(bam_atan2(t4, t5));
    return e;
  endfunction

  function automatic pose_t make_pose(int qx, int qy, int qz, int qw);
    pose_t p;
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz); p.qw = 16'(qw);
    return p;
  endfunction

  // mostly components within +-0.5, with raw noise mixed in
  function automatic pose_t random_pose();
    pose_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p = make_pose($urandom, $urandom, $urandom, $urandom);
    if (sel < 6) begin
      p.qx = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
      p.qy = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
      p.qz = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
      p.qw = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
    end else if (sel == 6) begin
      p.qy = '0; p.qz = '0;
    end
    return p;
  endfunction

  // s_tready is settled by the falling edge; the next rising edge takes the item
  task automatic send_pose(pose_t p);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= p;
    s_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    expected_q.insert(expected_q.size(), pose_to_euler(p));
    n_sent++;
  endtask

  task automatic drain_pending();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall and check against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        euler_t got, exp_r;
        got = m_tdata;
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          n_got++;
          if (got.x !== exp_r.x) begin
            $error("out_x exp %0d got %0d", exp_r.x, got.x); errors++;
          end
          if (got.y !== exp_r.y) begin
            $error("out_y exp %0d got %0d", exp_r.y, got.y); errors++;
          end
          if (got.z !== exp_r.z) begin
            $error("out_z exp %0d got %0d", exp_r.z, got.z); errors++;
          end
          if (got.yaw !== exp_r.yaw) begin
            $error("yaw_angle exp %0d got %0d", exp_r.yaw, got.yaw); errors++;
          end
          if (got.pitch !== exp_r.pitch) begin
            $error("pitch_angle exp %0d got %0d", exp_r.pitch, got.pitch); errors++;
          end
          if (got.roll !== exp_r.roll) begin
            $error("roll_angle exp %0d got %0d", exp_r.roll, got.roll); errors++;
          end
        end
      end
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || sending_done) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int wait_cnt;
    // directed: identity, zero, extremes, half-turns, gimbal lock, non-unit
    r.fixed = 1; r.angles = '0;
    r.pose = make_pose(0, 0, 0, 16384); rows.insert(rows.size(), r);   // identity: all zero
    r.pose = make_pose(0, 0, 0, 0); rows.insert(rows.size(), r);       // zero quaternion
    r.fixed = 0;
    r.pose = make_pose(0, 0, 16384, 0); rows.insert(rows.size(), r);   // yaw half-turn, x < 0
    r.pose = make_pose(16384, 0, 0, 0); rows.insert(rows.size(), r);   // roll half-turn
    r.pose = make_pose(0, 11585, 0, 11585); rows.insert(rows.size(), r);   // pitch +90
    r.pose = make_pose(0, -11585, 0, 11585); rows.insert(rows.size(), r);  // pitch -90
    r.pose = make_pose(0, 16384, 0, 16384); rows.insert(rows.size(), r);   // asin clamp high
    r.pose = make_pose(16384, 0, 16384, 0); rows.insert(rows.size(), r);   // asin clamp low
    r.pose = make_pose(-32768, -32768, -32768, -32768); rows.insert(rows.size(), r);
    r.pose = make_pose(32767, 32767, 32767, 32767); rows.insert(rows.size(), r);
    r.pose = make_pose(32767, -32768, 32767, -32768); rows.insert(rows.size(), r);
    r.pose = make_pose(0, 0, -16384, 16384); rows.insert(rows.size(), r);  // yaw -90: x = 0, y < 0
    r.pose = make_pose(0, 0, 16384, -100); rows.insert(rows.size(), r);
    r.pose = make_pose(1, -1, 1, -1); rows.insert(rows.size(), r);
    r.pose = make_pose(-32768, 0, 0, 0); rows.insert(rows.size(), r);
    r.pose = make_pose(0, 0, 0, -32768); rows.insert(rows.size(), r);
    r.pose = make_pose(0, 0, 0, 16384);
    r.pose.px = 32'sh80000000; r.pose.py = 32'sh7fffffff; r.pose.pz = 32'hffffffff;
    rows.insert(rows.size(), r);
    r.pose.px = 32'sh7fffffff; r.pose.py = 32'sh80000000; r.pose.pz = 0;
    rows.insert(rows.size(), r);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_pose(rows[i].pose);
      if (rows[i].fixed) begin
        // yaw/pitch/roll typed in; position comes from the row
        expected_q[$].yaw = rows[i].angles.yaw;
        expected_q[$].pitch = rows[i].angles.pitch;
        expected_q[$].roll = rows[i].angles.roll;
      end
    end
    drain_pending();

    // random part over the idling phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) send_pose(random_pose());
      if (ph == 2) drain_pending();   // sender holds off until all results are back
    end

    s_tvalid <= 1'b0;
    sending_done = 1'b1;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 50 * WATCHDOG) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (expected_q.size() != 0) begin
      $display("CHECKS FAILED");
      $finish;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d poses (%0d results) across directed extremes, gimbal lock,",
             n_sent, n_got);
    $display("asin clamping, and random idle/stall phases.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
